// ===== rtl/scsa_pkg.sv =====
// Shared constants and types for the size-class bitmap slot allocator.
`timescale 1ns / 1ps
package scsa_pkg;

    localparam int NUM_CLASSES     = 16;
    localparam int SLOTS_PER_CLASS = 64;
    localparam int SIZE_W          = 16;
    localparam int ADDR_W          = 32;
    localparam int CLASS_W         = 4;
    localparam int SLOT_W          = $clog2(SLOTS_PER_CLASS);
    localparam int CLASS_WIDE_W    = SIZE_W - 3;

    localparam logic [ADDR_W-1:0]          HEADER_BYTES   = 32'd8;
    localparam logic [SLOTS_PER_CLASS-1:0] ALL_SLOTS_USED = {SLOTS_PER_CLASS{1'b1}};

    localparam logic [1:0] ST_GRANTED   = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;

    typedef struct packed {
        logic               valid;
        logic               too_large;
        logic [CLASS_W-1:0] cls;
    } req_t;

    typedef struct packed {
        logic              full;
        logic [SLOT_W-1:0] slot;
    } pick_t;

endpackage

// ===== rtl/scsa_req_stage.sv =====
// Request input register and size-class decode.
`timescale 1ns / 1ps
module scsa_req_stage
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [scsa_pkg::SIZE_W-1:0] req_size,
    output scsa_pkg::req_t              req
);

    logic                              valid_reg;
    logic [scsa_pkg::SIZE_W-1:0]       size_reg;
    logic [scsa_pkg::SIZE_W-1:0]       size_m1;
    logic [scsa_pkg::CLASS_WIDE_W-1:0] cls_wide;
    logic                              too_large;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            size_reg <= req_size;
        end
    end

    // class = ceil(size / 8) - 1, with sizes up to 8 in class zero
    always_comb
    begin
        size_m1   = size_reg - 16'd1;
        cls_wide  = (size_reg == '0) ? '0 : size_m1[scsa_pkg::SIZE_W-1:3];
        too_large = (cls_wide >= scsa_pkg::CLASS_WIDE_W'(scsa_pkg::NUM_CLASSES));
        req.valid     = valid_reg;
        req.too_large = too_large;
        req.cls       = too_large ? '0 : cls_wide[scsa_pkg::CLASS_W-1:0];
    end

endmodule

// ===== rtl/scsa_slot_pick.sv =====
// Lowest-clear-bit search over one class bitmap.
`timescale 1ns / 1ps
module scsa_slot_pick
(
    input  logic [scsa_pkg::SLOTS_PER_CLASS-1:0] word,
    output scsa_pkg::pick_t                      pick
);

    logic [scsa_pkg::SLOTS_PER_CLASS-1:0] word_inv;
    logic [scsa_pkg::SLOTS_PER_CLASS-1:0] lowest;
    logic [scsa_pkg::SLOT_W-1:0]          slot;

    // isolate the lowest clear bit, then encode its position
    always_comb
    begin
        word_inv = ~word;
        lowest   = word_inv & (~word_inv + {{(scsa_pkg::SLOTS_PER_CLASS-1){1'b0}}, 1'b1});
        slot     = '0;
        for (int k = 0; k < scsa_pkg::SLOT_W; k++)
        begin
            for (int i = 0; i < scsa_pkg::SLOTS_PER_CLASS; i++)
            begin
                if (((i >> k) & 1) != 0)
                begin
                    slot[k] = slot[k] | lowest[i];
                end
            end
        end
        pick.full = (word == scsa_pkg::ALL_SLOTS_USED);
        pick.slot = slot;
    end

endmodule

// ===== rtl/size_class_bitmap_slot_allocator.sv =====
// A request is registered in scsa_req_stage; its result, with done high, is then registered here.
// Throughput: one request per cycle; busy stays low and start may be held high every cycle.
// Bitmap, region table and bump pointer update at the same edge as the result register.
// Reset clears every class and loads the bump pointer with zero; done is low after reset.
// Results last one cycle and cannot be stalled by the receiver.
`timescale 1ns / 1ps
module size_class_bitmap_slot_allocator
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [scsa_pkg::SIZE_W-1:0]  req_size,
    input  logic                         cfg_we,
    input  logic [scsa_pkg::ADDR_W-1:0]  cfg_data,
    output logic                         done,
    output logic [1:0]                   status,
    output logic [scsa_pkg::ADDR_W-1:0]  address,
    output logic [scsa_pkg::CLASS_W-1:0] class_index,
    output logic [scsa_pkg::SLOT_W-1:0]  slot_index
);

    scsa_pkg::req_t  req;
    scsa_pkg::pick_t pick;

    logic [scsa_pkg::SLOTS_PER_CLASS-1:0] bitmap_reg [scsa_pkg::NUM_CLASSES];
    logic [scsa_pkg::ADDR_W-1:0]          start_reg  [scsa_pkg::NUM_CLASSES];
    logic [scsa_pkg::NUM_CLASSES-1:0]     present_reg;
    logic [scsa_pkg::ADDR_W-1:0]          bump_reg;

    logic                         done_reg;
    logic [1:0]                   status_reg;
    logic [scsa_pkg::ADDR_W-1:0]  address_reg;
    logic [scsa_pkg::CLASS_W-1:0] class_reg;
    logic [scsa_pkg::SLOT_W-1:0]  slot_reg;

    logic [scsa_pkg::SLOTS_PER_CLASS-1:0] cur_bitmap;
    logic                                 present;
    logic [scsa_pkg::ADDR_W-1:0]          region;
    logic [scsa_pkg::CLASS_W:0]           cls1;
    logic [scsa_pkg::SLOT_W-1:0]          eff_slot;
    logic [scsa_pkg::SLOT_W+scsa_pkg::CLASS_W:0] slot_mult;
    logic [scsa_pkg::ADDR_W-1:0]          grant_addr;
    logic [scsa_pkg::ADDR_W-1:0]          bump_next;
    logic                                 do_new;
    logic                                 do_take;
    logic [1:0]                           status_next;
    logic [scsa_pkg::ADDR_W-1:0]          address_next;
    logic [scsa_pkg::SLOT_W-1:0]          slot_next;

    scsa_req_stage u_req
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_size (req_size),
        .req      (req)
    );

    scsa_slot_pick u_pick
    (
        .word (cur_bitmap),
        .pick (pick)
    );

    always_comb
    begin
        cur_bitmap = bitmap_reg[req.cls];
        present    = present_reg[req.cls];
        region     = present ? start_reg[req.cls] : bump_reg;
        cls1       = {1'b0, req.cls} + 5'd1;
        eff_slot   = present ? pick.slot : '0;
        slot_mult  = eff_slot * cls1;
        grant_addr = region + scsa_pkg::HEADER_BYTES
                     + scsa_pkg::ADDR_W'({slot_mult, 3'b000});
        // region spans SLOTS_PER_CLASS slots of (class+1)*8 bytes plus a header
        bump_next  = bump_reg + scsa_pkg::ADDR_W'({cls1, 9'b0}) + scsa_pkg::HEADER_BYTES;

        do_new  = req.valid && !req.too_large && !present;
        do_take = req.valid && !req.too_large && present && !pick.full;

        priority if (req.too_large)
        begin
            status_next  = scsa_pkg::ST_TOO_LARGE;
            address_next = '0;
            slot_next    = '0;
        end
        else if (present && pick.full)
        begin
            status_next  = scsa_pkg::ST_FULL;
            address_next = '0;
            slot_next    = '0;
        end
        else
        begin
            status_next  = scsa_pkg::ST_GRANTED;
            address_next = grant_addr;
            slot_next    = eff_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            bump_reg    <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= req.valid;
            if (cfg_we)
            begin
                bump_reg <= cfg_data;
            end
            else if (do_new)
            begin
                bump_reg <= bump_next;
            end
            if (do_new)
            begin
                present_reg[req.cls] <= 1'b1;
            end
        end
    end

    // bitmap of an absent class is never read, so no reset is needed
    always_ff @(posedge clk)
    begin
        if (do_new)
        begin
            start_reg[req.cls]  <= bump_reg;
            bitmap_reg[req.cls] <= {{(scsa_pkg::SLOTS_PER_CLASS-1){1'b0}}, 1'b1};
        end
        else if (do_take)
        begin
            bitmap_reg[req.cls] <= cur_bitmap
                | ({{(scsa_pkg::SLOTS_PER_CLASS-1){1'b0}}, 1'b1} << pick.slot);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid)
        begin
            status_reg  <= status_next;
            address_reg <= address_next;
            class_reg   <= req.cls;
            slot_reg    <= slot_next;
        end
    end

    assign busy        = 1'b0;
    assign done        = done_reg;
    assign status      = status_reg;
    assign address     = address_reg;
    assign class_index = class_reg;
    assign slot_index  = slot_reg;

endmodule
